/* src/adrs_pkg.sv */
// Shared types, constants and sizes for the ATA DMA request sequencer.
// No dependencies; adrs_front, adrs_cmd_fifo, adrs_back and the top use scoped names, the checker and tb import it.
package adrs_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int BUS_COUNT   = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W      = $clog2(2 * QUEUE_DEPTH);
   localparam int SLOTS       = 2 * QUEUE_DEPTH;

   // request function codes
   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_REPORT = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // result item kinds
   localparam logic [2:0] KIND_BYTE   = 3'd0;
   localparam logic [2:0] KIND_DWORD  = 3'd1;
   localparam logic [2:0] KIND_PRD    = 3'd2;
   localparam logic [2:0] KIND_DONE   = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   // rejection codes
   localparam logic [1:0] REJ_NO_DRIVE = 2'd0;
   localparam logic [1:0] REJ_RANGE    = 2'd1;
   localparam logic [1:0] REJ_SIZE     = 2'd2;
   localparam logic [1:0] REJ_FULL     = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_BM_BASE  = 3'd0;
   localparam logic [2:0] CSR_PRD_BASE = 3'd1;
   localparam logic [2:0] CSR_PRESENT  = 3'd2;
   localparam logic [2:0] CSR_LBA48    = 3'd3;
   localparam logic [2:0] CSR_SECT0    = 3'd4;
   localparam logic [2:0] CSR_SECT1    = 3'd5;
   localparam logic [2:0] CSR_SECT2    = 3'd6;
   localparam logic [2:0] CSR_SECT3    = 3'd7;

   // port and command constants
   localparam logic [15:0] PRI_BASE  = 16'h01f0;
   localparam logic [15:0] SEC_BASE  = 16'h0170;
   localparam logic [15:0] PRI_CTL   = 16'h03f4 + 16'd2;
   localparam logic [15:0] SEC_CTL   = 16'h0374 + 16'd2;
   localparam logic [7:0]  CMD_RD28  = 8'hc8;
   localparam logic [7:0]  CMD_RD48  = 8'h25;
   localparam logic [7:0]  CMD_WR28  = 8'hca;
   localparam logic [7:0]  CMD_WR48  = 8'h35;
   localparam logic [7:0]  DEV_LBA48 = 8'h40;
   localparam logic [7:0]  DEV_LBA28 = 8'he0;
   localparam logic [7:0]  CTL_SRST  = 8'h04;
   localparam logic [7:0]  BM_ERR    = 8'h02;

   typedef struct packed {
      logic [15:0]      bm_base;
      logic [31:0]      prd_base;
      logic [3:0]       present;
      logic [3:0]       lba48;
      logic [3:0][47:0] sectors;
   } cfg_type;

   // classified input item, front to back
   typedef struct packed {
      logic        is_report;
      logic        is_write;
      logic [1:0]  drv;
      logic [47:0] start_lba;
      logic [15:0] cnt;
      logic [31:0] buf_addr;
      logic [15:0] size;
      logic [7:0]  tag;
      logic        l48;
      logic        reject;
      logic [1:0]  code;
      logic        report_bus;
      logic [7:0]  status;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [15:0] port_address;
      logic [31:0] write_data;
      logic [15:0] prd_byte_count;
      logic [7:0]  done_tag;
      logic        failed;
      logic [1:0]  reject_code;
      logic        last;
   } rsp_item_type;

endpackage

/* src/adrs_if.sv */
// Channel interfaces for request and result transfers.
// Depends on nothing but plain logic types.
interface adrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [1:0]  drive_number;
   logic [47:0] start_lba;
   logic [15:0] sector_total;
   logic [31:0] buffer_address;
   logic [15:0] buffer_bytes;
   logic [7:0]  request_tag;
   logic        report_bus;
   logic [7:0]  bm_status_byte;
   modport source (output valid, func, drive_number, start_lba, sector_total,
                   buffer_address, buffer_bytes, request_tag, report_bus,
                   bm_status_byte, input ready);
   modport sink (input valid, func, drive_number, start_lba, sector_total,
                 buffer_address, buffer_bytes, request_tag, report_bus,
                 bm_status_byte, output ready);
endinterface

interface adrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  item_kind;
   logic [15:0] port_address;
   logic [31:0] write_data;
   logic [15:0] prd_byte_count;
   logic [7:0]  done_tag;
   logic        failed;
   logic [1:0]  reject_code;
   logic        last;
   modport source (output valid, item_kind, port_address, write_data,
                   prd_byte_count, done_tag, failed, reject_code, last,
                   input ready);
   modport sink (input valid, item_kind, port_address, write_data,
                 prd_byte_count, done_tag, failed, reject_code, last,
                 output ready);
endinterface

/* src/adrs_front.sv */
// Front end: takes request transfers, checks drive, range and size.
// Depends on adrs_pkg and adrs_if.
module adrs_front (
   adrs_req_if.sink          req,
   input  adrs_pkg::cfg_type cfg,
   input  logic              cmd_ready,
   output logic              cmd_valid,
   output adrs_pkg::cmd_type cmd
);
   logic        bus;
   logic [47:0] total;
   logic [48:0] diff;
   logic        absent;
   logic        bad_range;
   logic        bad_size;

   assign bus   = req.drive_number[1];
   assign total = cfg.sectors[req.drive_number];
   assign diff  = {1'b0, total} - {1'b0, req.start_lba};

   always_comb begin
      absent    = (int'(bus) >= adrs_pkg::BUS_COUNT) || !cfg.present[req.drive_number];
      // start must lie below the drive end and leave room for the count
      bad_range = diff[48] || (diff[47:0] == 48'd0) ||
                  (diff[47:0] < {32'd0, req.sector_total});
      bad_size  = (req.sector_total[15:7] != 9'd0) ||
                  (req.buffer_bytes != {req.sector_total[6:0], 9'd0});
   end

   always_comb begin
      cmd            = '0;
      cmd.is_report  = (req.func == adrs_pkg::FUNC_REPORT);
      cmd.is_write   = (req.func == adrs_pkg::FUNC_WRITE);
      cmd.drv        = req.drive_number;
      cmd.start_lba  = req.start_lba;
      cmd.cnt        = req.sector_total;
      cmd.buf_addr   = req.buffer_address;
      cmd.size       = req.buffer_bytes;
      cmd.tag        = req.request_tag;
      cmd.l48        = cfg.lba48[req.drive_number];
      cmd.report_bus = req.report_bus;
      cmd.status     = req.bm_status_byte;
      cmd.reject     = absent || bad_range || bad_size;
      if (absent) begin
         cmd.code = adrs_pkg::REJ_NO_DRIVE;
      end else if (bad_range) begin
         cmd.code = adrs_pkg::REJ_RANGE;
      end else begin
         cmd.code = adrs_pkg::REJ_SIZE;
      end
   end

   // an unused function code is taken and dropped
   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid && (req.func != adrs_pkg::FUNC_NONE);

endmodule

/* src/adrs_cmd_fifo.sv */
// Two-entry queue of classified commands between front and back.
// Depends on adrs_pkg.
module adrs_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  adrs_pkg::cmd_type push_cmd,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output adrs_pkg::cmd_type pop_cmd
);
   adrs_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && not_full) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && not_full) wr_ptr_ff <= !wr_ptr_ff;
         if (pop && not_empty) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push && not_full} - {1'b0, pop && not_empty};
      end
   end

endmodule

/* src/adrs_back.sv */
// Back end: per-bus request queues and the port write sequencer.
// Depends on adrs_pkg.
module adrs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  adrs_pkg::cfg_type      cfg,
   input  logic                   cmd_valid,
   input  adrs_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output adrs_pkg::rsp_item_type rsp_item
);
   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_REJECT, S_RESET, S_COMPLETE, S_LOAD, S_START, S_DONE
   } state_type;

   typedef struct packed {
      logic [47:0] lba;
      logic [1:0]  drv;
      logic [15:0] cnt;
      logic [15:0] size;
      logic [7:0]  tag;
      logic        wr;
      logic        l48;
      logic [31:0] buf_addr;
   } entry_type;

   localparam logic [adrs_pkg::FILL_W-1:0] FILL_FULL = adrs_pkg::FILL_W'(adrs_pkg::QUEUE_DEPTH);
   localparam logic [adrs_pkg::PTR_W-1:0]  PTR_LAST  = adrs_pkg::PTR_W'(adrs_pkg::QUEUE_DEPTH - 1);

   state_type                    state_ff;
   adrs_pkg::cmd_type            cmd_ff;
   logic                         bus_ff;
   logic [3:0]                   step_ff;
   logic                         then_done_ff;
   logic                         failed_ff;
   logic [7:0]                   done_tag_ff;
   logic [1:0]                   reject_code_ff;
   logic [adrs_pkg::PTR_W-1:0]   head_ff [2];
   logic [adrs_pkg::PTR_W-1:0]   tail_ff [2];
   logic [adrs_pkg::FILL_W-1:0]  fill_ff [2];
   logic                         retry_ff [2];
   logic [7:0]                   head_tag_ff [2];
   entry_type                    entry_ff;
   entry_type                    queue_mem [adrs_pkg::SLOTS];
   logic                         rsp_valid_ff;
   adrs_pkg::rsp_item_type       rsp_item_ff;

   logic                         out_free;
   logic                         sub_bus;
   logic                         rep_bus;
   logic                         mem_we;
   logic [adrs_pkg::SLOT_W-1:0]  wr_slot;
   logic [adrs_pkg::SLOT_W-1:0]  rd_slot;
   entry_type                    new_entry;
   adrs_pkg::rsp_item_type       seq_item;
   adrs_pkg::rsp_item_type       out_item;
   logic                         out_load;
   logic [3:0]                   last_step;
   logic [15:0]                  bm_port;
   logic [15:0]                  tf_base;
   logic [15:0]                  ctl_port;
   logic [7:0]                   cmd_code;
   logic [3:0]                   ms_bit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sub_bus  = cmd_ff.drv[1];
   assign rep_bus  = cmd_ff.report_bus;
   assign cmd_pop  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign mem_we = (state_ff == S_EXEC) && !cmd_ff.is_report && !cmd_ff.reject &&
                   (fill_ff[sub_bus] != FILL_FULL);
   assign wr_slot = adrs_pkg::SLOT_W'(sub_bus) * adrs_pkg::SLOT_W'(adrs_pkg::QUEUE_DEPTH)
                    + adrs_pkg::SLOT_W'(tail_ff[sub_bus]);
   assign rd_slot = adrs_pkg::SLOT_W'(bus_ff) * adrs_pkg::SLOT_W'(adrs_pkg::QUEUE_DEPTH)
                    + adrs_pkg::SLOT_W'(head_ff[bus_ff]);

   always_comb begin
      new_entry          = '0;
      new_entry.lba      = cmd_ff.start_lba;
      new_entry.drv      = cmd_ff.drv;
      new_entry.cnt      = cmd_ff.cnt;
      new_entry.size     = cmd_ff.size;
      new_entry.tag      = cmd_ff.tag;
      new_entry.wr       = cmd_ff.is_write;
      new_entry.l48      = cmd_ff.l48;
      new_entry.buf_addr = cmd_ff.buf_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wr_slot] <= new_entry;
      end
      if (state_ff == S_LOAD) begin
         entry_ff <= queue_mem[rd_slot];
      end
   end

   // one item of the start sequence, selected by step
   always_comb begin
      bm_port   = cfg.bm_base + {12'd0, bus_ff, 3'd0};
      tf_base   = bus_ff ? adrs_pkg::SEC_BASE : adrs_pkg::PRI_BASE;
      ctl_port  = bus_ff ? adrs_pkg::SEC_CTL : adrs_pkg::PRI_CTL;
      ms_bit    = {3'd0, entry_ff.drv[0]};
      last_step = entry_ff.l48 ? 4'd13 : 4'd10;
      if (entry_ff.wr) begin
         cmd_code = entry_ff.l48 ? adrs_pkg::CMD_WR48 : adrs_pkg::CMD_WR28;
      end else begin
         cmd_code = entry_ff.l48 ? adrs_pkg::CMD_RD48 : adrs_pkg::CMD_RD28;
      end
      seq_item           = '0;
      seq_item.item_kind = adrs_pkg::KIND_BYTE;
      case (step_ff)
         4'd0: begin
            seq_item.item_kind      = adrs_pkg::KIND_PRD;
            seq_item.write_data     = entry_ff.buf_addr;
            seq_item.prd_byte_count = entry_ff.size;
         end
         4'd1: seq_item.port_address = bm_port;
         4'd2: begin
            seq_item.item_kind    = adrs_pkg::KIND_DWORD;
            seq_item.port_address = bm_port + 16'd4;
            seq_item.write_data   = cfg.prd_base + {28'd0, bus_ff, 3'd0};
         end
         4'd3: begin
            seq_item.port_address = bm_port;
            seq_item.write_data   = {28'd0, !entry_ff.wr, 3'b001};
         end
         default: begin
            if (entry_ff.l48) begin
               case (step_ff)
                  4'd4: begin
                     seq_item.port_address = tf_base + 16'd6;
                     seq_item.write_data   = {24'd0, adrs_pkg::DEV_LBA48 | {ms_bit, 4'd0}};
                  end
                  4'd5: begin
                     seq_item.port_address = tf_base + 16'd2;
                     seq_item.write_data   = {24'd0, entry_ff.cnt[15:8]};
                  end
                  4'd6: begin
                     seq_item.port_address = tf_base + 16'd3;
                     seq_item.write_data   = {24'd0, entry_ff.lba[31:24]};
                  end
                  4'd7: begin
                     seq_item.port_address = tf_base + 16'd4;
                     seq_item.write_data   = {24'd0, entry_ff.lba[39:32]};
                  end
                  4'd8: begin
                     seq_item.port_address = tf_base + 16'd5;
                     seq_item.write_data   = {24'd0, entry_ff.lba[47:40]};
                  end
                  4'd9: begin
                     seq_item.port_address = tf_base + 16'd2;
                     seq_item.write_data   = {24'd0, entry_ff.cnt[7:0]};
                  end
                  4'd10: begin
                     seq_item.port_address = tf_base + 16'd3;
                     seq_item.write_data   = {24'd0, entry_ff.lba[7:0]};
                  end
                  4'd11: begin
                     seq_item.port_address = tf_base + 16'd4;
                     seq_item.write_data   = {24'd0, entry_ff.lba[15:8]};
                  end
                  4'd12: begin
                     seq_item.port_address = tf_base + 16'd5;
                     seq_item.write_data   = {24'd0, entry_ff.lba[23:16]};
                  end
                  default: begin
                     seq_item.port_address = tf_base + 16'd7;
                     seq_item.write_data   = {24'd0, cmd_code};
                  end
               endcase
            end else begin
               case (step_ff)
                  4'd4: begin
                     seq_item.port_address = tf_base + 16'd6;
                     seq_item.write_data   = {24'd0, adrs_pkg::DEV_LBA28 | {ms_bit, 4'd0}
                                              | {4'd0, entry_ff.lba[27:24]}};
                  end
                  4'd5: seq_item.port_address = tf_base + 16'd1;
                  4'd6: begin
                     seq_item.port_address = tf_base + 16'd2;
                     seq_item.write_data   = {24'd0, entry_ff.cnt[7:0]};
                  end
                  4'd7: begin
                     seq_item.port_address = tf_base + 16'd3;
                     seq_item.write_data   = {24'd0, entry_ff.lba[7:0]};
                  end
                  4'd8: begin
                     seq_item.port_address = tf_base + 16'd4;
                     seq_item.write_data   = {24'd0, entry_ff.lba[15:8]};
                  end
                  4'd9: begin
                     seq_item.port_address = tf_base + 16'd5;
                     seq_item.write_data   = {24'd0, entry_ff.lba[23:16]};
                  end
                  default: begin
                     seq_item.port_address = tf_base + 16'd7;
                     seq_item.write_data   = {24'd0, cmd_code};
                  end
               endcase
            end
         end
      endcase
      seq_item.last = (step_ff == last_step) && !then_done_ff;
   end

   // item loaded into the output register in the current state
   always_comb begin
      out_item = '0;
      out_load = 1'b0;
      unique case (state_ff)
         S_REJECT: begin
            out_load             = out_free;
            out_item.item_kind   = adrs_pkg::KIND_REJECT;
            out_item.done_tag    = cmd_ff.tag;
            out_item.reject_code = reject_code_ff;
            out_item.last        = 1'b1;
         end
         S_RESET: begin
            // clear bus-master status, pulse soft reset
            out_load           = out_free;
            out_item.item_kind = adrs_pkg::KIND_BYTE;
            if (step_ff == 4'd0) begin
               out_item.port_address = bm_port + 16'd2;
               out_item.write_data   = {24'd0, adrs_pkg::BM_ERR};
            end else begin
               out_item.port_address = ctl_port;
               out_item.write_data   = (step_ff == 4'd1) ?
                                       {24'd0, adrs_pkg::CTL_SRST} : 32'd0;
            end
         end
         S_START: begin
            out_load = out_free;
            out_item = seq_item;
         end
         S_DONE: begin
            out_load           = out_free;
            out_item.item_kind = adrs_pkg::KIND_DONE;
            out_item.done_tag  = done_tag_ff;
            out_item.failed    = failed_ff;
            out_item.last      = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         then_done_ff   <= 1'b0;
         step_ff        <= 4'd0;
         bus_ff         <= 1'b0;
         failed_ff      <= 1'b0;
         for (int b = 0; b < 2; b++) begin
            head_ff[b]  <= '0;
            tail_ff[b]  <= '0;
            fill_ff[b]  <= '0;
            retry_ff[b] <= 1'b0;
         end
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_item_ff  <= out_item;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (!cmd_ff.is_report) begin
                  if (cmd_ff.reject) begin
                     reject_code_ff <= cmd_ff.code;
                     state_ff       <= S_REJECT;
                  end else if (fill_ff[sub_bus] == FILL_FULL) begin
                     reject_code_ff <= adrs_pkg::REJ_FULL;
                     state_ff       <= S_REJECT;
                  end else begin
                     tail_ff[sub_bus] <= (tail_ff[sub_bus] == PTR_LAST) ? '0
                                         : tail_ff[sub_bus] + 1'b1;
                     fill_ff[sub_bus] <= fill_ff[sub_bus] + 1'b1;
                     bus_ff           <= sub_bus;
                     then_done_ff     <= 1'b0;
                     state_ff <= (fill_ff[sub_bus] == '0) ? S_LOAD : S_IDLE;
                  end
               end else if ((int'(rep_bus) >= adrs_pkg::BUS_COUNT) ||
                            (fill_ff[rep_bus] == '0)) begin
                  state_ff <= S_IDLE;
               end else begin
                  bus_ff  <= rep_bus;
                  step_ff <= 4'd0;
                  if (cmd_ff.status[1]) begin
                     state_ff <= S_RESET;
                  end else if (!cmd_ff.status[0]) begin
                     failed_ff <= 1'b0;
                     state_ff  <= S_COMPLETE;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_REJECT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_RESET: begin
               if (out_free) begin
                  if (step_ff == 4'd2) begin
                     step_ff <= 4'd0;
                     if (!retry_ff[bus_ff]) begin
                        retry_ff[bus_ff] <= 1'b1;
                        then_done_ff     <= 1'b0;
                        state_ff         <= S_LOAD;
                     end else begin
                        failed_ff <= 1'b1;
                        state_ff  <= S_COMPLETE;
                     end
                  end else begin
                     step_ff <= step_ff + 4'd1;
                  end
               end
            end
            S_COMPLETE: begin
               done_tag_ff      <= head_tag_ff[bus_ff];
               head_ff[bus_ff]  <= (head_ff[bus_ff] == PTR_LAST) ? '0 : head_ff[bus_ff] + 1'b1;
               fill_ff[bus_ff]  <= fill_ff[bus_ff] - 1'b1;
               retry_ff[bus_ff] <= 1'b0;
               if (fill_ff[bus_ff] > adrs_pkg::FILL_W'(1)) begin
                  then_done_ff <= 1'b1;
                  state_ff     <= S_LOAD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_LOAD: begin
               head_tag_ff[bus_ff] <= queue_mem[rd_slot].tag;
               step_ff             <= 4'd0;
               state_ff            <= S_START;
            end
            S_START: begin
               if (out_free) begin
                  step_ff <= step_ff + 4'd1;
                  if (step_ff == last_step) begin
                     state_ff <= then_done_ff ? S_DONE : S_IDLE;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  then_done_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= FILL_FULL) && (fill_ff[1] <= FILL_FULL))
      else $error("queue fill above depth");

   a_retry_needs_head: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[bus_ff] == '0) |-> !retry_ff[bus_ff])
      else $error("retry flag set on empty queue");

   a_start_has_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> (fill_ff[bus_ff] != '0))
      else $error("start sequence with empty queue");

   a_load_to_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_START))
      else $error("entry load not followed by start");

endmodule

/* src/ata_dma_request_sequencer.sv */
// Top level of the ATA DMA request sequencer: registers, front, queue, back.
// Depends on adrs_pkg, adrs_if, adrs_front, adrs_cmd_fifo and adrs_back.
//
// Requests and bus-master status reports enter on req_ch; port writes, PRD
// entries, completions and rejections leave on rsp_ch, one transfer per
// cycle at most and only while the consumer is ready, the last one of each
// input marked by last. The front checks each request combinationally and
// queues it in a two-entry command queue; the back finishes each command
// before it takes the next: a request start loads the entry from the per-bus
// request memory, then sends a PRD entry and the LBA28 or LBA48 port writes;
// an error recovery first clears bus-master status and pulses soft reset.
// The output register lets the back keep working, up to its next transfer,
// while the consumer holds off a finished transfer. Registers are written
// through csr_we/csr_index/csr_wdata while no work is pending: the user must
// keep to this, as the block does not enforce it; there is no read-back.
module ata_dma_request_sequencer (
   input  logic        clock,
   input  logic        reset,
   adrs_req_if.sink    req_ch,
   adrs_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   adrs_pkg::cfg_type      cfg_ff;
   adrs_pkg::cmd_type      front_cmd;
   adrs_pkg::cmd_type      back_cmd;
   adrs_pkg::rsp_item_type item;
   logic                   front_valid;
   logic                   fifo_not_full;
   logic                   fifo_not_empty;
   logic                   back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            adrs_pkg::CSR_BM_BASE:  cfg_ff.bm_base    <= csr_wdata[15:0];
            adrs_pkg::CSR_PRD_BASE: cfg_ff.prd_base   <= csr_wdata[31:0];
            adrs_pkg::CSR_PRESENT:  cfg_ff.present    <= csr_wdata[3:0];
            adrs_pkg::CSR_LBA48:    cfg_ff.lba48      <= csr_wdata[3:0];
            adrs_pkg::CSR_SECT0:    cfg_ff.sectors[0] <= csr_wdata;
            adrs_pkg::CSR_SECT1:    cfg_ff.sectors[1] <= csr_wdata;
            adrs_pkg::CSR_SECT2:    cfg_ff.sectors[2] <= csr_wdata;
            adrs_pkg::CSR_SECT3:    cfg_ff.sectors[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   adrs_front u_front (
      .req       (req_ch),
      .cfg       (cfg_ff),
      .cmd_ready (fifo_not_full),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   adrs_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .not_full  (fifo_not_full),
      .pop       (back_pop),
      .not_empty (fifo_not_empty),
      .pop_cmd   (back_cmd)
   );

   adrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (fifo_not_empty),
      .cmd       (back_cmd),
      .cmd_pop   (back_pop),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (item)
   );

   assign rsp_ch.item_kind      = item.item_kind;
   assign rsp_ch.port_address   = item.port_address;
   assign rsp_ch.write_data     = item.write_data;
   assign rsp_ch.prd_byte_count = item.prd_byte_count;
   assign rsp_ch.done_tag       = item.done_tag;
   assign rsp_ch.failed         = item.failed;
   assign rsp_ch.reject_code    = item.reject_code;
   assign rsp_ch.last           = item.last;

endmodule

/* verif/adrs_checker.sv */
// Checker for the ATA DMA request sequencer: watches both channels, predicts results.
// Depends on adrs_pkg and adrs_if; csr writes are mirrored from the top's ports.
module adrs_checker (
   input  logic        clock,
   input  logic        reset,
   adrs_req_if         req_ch,
   adrs_rsp_if         rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import adrs_pkg::*;

   typedef struct {
      logic [47:0] lba;
      logic [31:0] buf_addr;
      logic [15:0] cnt;
      logic [15:0] size;
      logic [7:0]  tag;
      logic [1:0]  drv;
      logic        wr;
      logic        l48;
   } job_type;

   cfg_type      cfg;
   job_type      jobs [2][$];
   logic         retried [2];
   rsp_item_type expected_items [$];

   function automatic rsp_item_type mk(logic [2:0] kind, logic [15:0] port,
                                       logic [31:0] data);
      rsp_item_type r;
      r = '0;
      r.item_kind = kind;
      r.port_address = port;
      r.write_data = data;
      return r;
   endfunction

   task automatic push_byte(logic [15:0] port, logic [7:0] data);
      expected_items.push_back(mk(KIND_BYTE, port, {24'd0, data}));
   endtask

   task automatic issue_head(int bus);
      job_type     j;
      logic [15:0] bm;
      logic [15:0] base;
      logic [7:0]  cmd;
      rsp_item_type r;
      j = jobs[bus][0];
      bm = cfg.bm_base + 16'(8 * bus);
      base = bus ? SEC_BASE : PRI_BASE;
      if (j.wr) cmd = j.l48 ? CMD_WR48 : CMD_WR28;
      else cmd = j.l48 ? CMD_RD48 : CMD_RD28;
      r = mk(KIND_PRD, 16'd0, j.buf_addr);
      r.prd_byte_count = j.size;
      expected_items.push_back(r);
      push_byte(bm, 8'd0);
      expected_items.push_back(mk(KIND_DWORD, bm + 16'd4, cfg.prd_base + 32'(8 * bus)));
      push_byte(bm, j.wr ? 8'h01 : 8'h09);
      if (j.l48) begin
         push_byte(base + 16'd6, DEV_LBA48 | {3'd0, j.drv[0], 4'd0});
         push_byte(base + 16'd2, j.cnt[15:8]);
         push_byte(base + 16'd3, j.lba[31:24]);
         push_byte(base + 16'd4, j.lba[39:32]);
         push_byte(base + 16'd5, j.lba[47:40]);
      end else begin
         push_byte(base + 16'd6, DEV_LBA28 | {3'd0, j.drv[0], j.lba[27:24]});
         push_byte(base + 16'd1, 8'd0);
      end
      push_byte(base + 16'd2, j.cnt[7:0]);
      push_byte(base + 16'd3, j.lba[7:0]);
      push_byte(base + 16'd4, j.lba[15:8]);
      push_byte(base + 16'd5, j.lba[23:16]);
      push_byte(base + 16'd7, cmd);
   endtask

   task automatic finish_head(int bus, logic bad);
      rsp_item_type r;
      r = mk(KIND_DONE, 16'd0, 32'd0);
      r.done_tag = jobs[bus][0].tag;
      r.failed = bad;
      void'(jobs[bus].pop_front());
      retried[bus] = 1'b0;
      if (jobs[bus].size() > 0) issue_head(bus);
      expected_items.push_back(r);
   endtask

   task automatic predict_transfer();
      int           old_size;
      int           bus;
      logic [47:0]  total;
      logic [2:0]   code;
      job_type      j;
      rsp_item_type r;
      logic [15:0]  ctl;
      old_size = expected_items.size();
      if (req_ch.func == FUNC_READ || req_ch.func == FUNC_WRITE) begin
         bus = req_ch.drive_number[1];
         total = cfg.sectors[req_ch.drive_number];
         code = 3'd4;
         if (!cfg.present[req_ch.drive_number]) code = {1'b0, REJ_NO_DRIVE};
         else if (req_ch.start_lba >= total ||
                  total - req_ch.start_lba < 48'(req_ch.sector_total))
            code = {1'b0, REJ_RANGE};
         else if (32'(req_ch.buffer_bytes) != 32'(req_ch.sector_total) * 32'd512)
            code = {1'b0, REJ_SIZE};
         else if (jobs[bus].size() >= QUEUE_DEPTH) code = {1'b0, REJ_FULL};
         if (code != 3'd4) begin
            r = mk(KIND_REJECT, 16'd0, 32'd0);
            r.done_tag = req_ch.request_tag;
            r.reject_code = code[1:0];
            expected_items.push_back(r);
         end else begin
            j.lba = req_ch.start_lba;
            j.buf_addr = req_ch.buffer_address;
            j.cnt = req_ch.sector_total;
            j.size = req_ch.buffer_bytes;
            j.tag = req_ch.request_tag;
            j.drv = req_ch.drive_number;
            j.wr = req_ch.func == FUNC_WRITE;
            j.l48 = cfg.lba48[req_ch.drive_number];
            jobs[bus].push_back(j);
            if (jobs[bus].size() == 1) issue_head(bus);
         end
      end else if (req_ch.func == FUNC_REPORT) begin
         bus = req_ch.report_bus;
         if (jobs[bus].size() > 0) begin
            if (req_ch.bm_status_byte[1]) begin
               ctl = bus ? SEC_CTL : PRI_CTL;
               push_byte(cfg.bm_base + 16'(8 * bus) + 16'd2, BM_ERR);
               push_byte(ctl, CTL_SRST);
               push_byte(ctl, 8'd0);
               if (!retried[bus]) begin
                  retried[bus] = 1'b1;
                  issue_head(bus);
               end else finish_head(bus, 1'b1);
            end else if (!req_ch.bm_status_byte[0]) finish_head(bus, 1'b0);
         end
      end
      if (expected_items.size() > old_size)
         expected_items[expected_items.size() - 1].last = 1'b1;
   endtask

   task automatic report(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_transfer();
      rsp_item_type e;
      if (expected_items.size() == 0) begin
         report("unexpected transfer, kind", rsp_ch.item_kind, 48'd0);
         return;
      end
      e = expected_items.pop_front();
      if (rsp_ch.item_kind != e.item_kind) report("item_kind", rsp_ch.item_kind, e.item_kind);
      if (rsp_ch.port_address != e.port_address)
         report("port_address", rsp_ch.port_address, e.port_address);
      if (rsp_ch.write_data != e.write_data)
         report("write_data", rsp_ch.write_data, e.write_data);
      if (rsp_ch.prd_byte_count != e.prd_byte_count)
         report("prd_byte_count", rsp_ch.prd_byte_count, e.prd_byte_count);
      if (rsp_ch.done_tag != e.done_tag) report("done_tag", rsp_ch.done_tag, e.done_tag);
      if (rsp_ch.failed != e.failed) report("failed", rsp_ch.failed, e.failed);
      if (rsp_ch.reject_code != e.reject_code)
         report("reject_code", rsp_ch.reject_code, e.reject_code);
      if (rsp_ch.last != e.last) report("last", rsp_ch.last, e.last);
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      cfg = '0;
      retried[0] = 1'b0;
      retried[1] = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BM_BASE:  cfg.bm_base = csr_wdata[15:0];
               CSR_PRD_BASE: cfg.prd_base = csr_wdata[31:0];
               CSR_PRESENT:  cfg.present = csr_wdata[3:0];
               CSR_LBA48:    cfg.lba48 = csr_wdata[3:0];
               default:      cfg.sectors[2'(csr_index - CSR_SECT0)] = csr_wdata;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) compare_transfer();
         if (req_ch.valid && req_ch.ready) predict_transfer();
         pending_count = expected_items.size();
      end
   end
endmodule

/* verif/tb.sv */
// Testbench top for the ATA DMA request sequencer: clock, reset, stimulus, verdict.
// Depends on adrs_pkg, adrs_if, the sequencer RTL and adrs_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import adrs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_BM_BASE;
   logic [47:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          calm = 1'b0;
   logic [47:0] sect_now [4];
   logic [7:0]  next_tag = 8'd0;

   adrs_req_if req_ch ();
   adrs_rsp_if rsp_ch ();

   ata_dma_request_sequencer dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   adrs_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count));

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || $urandom_range(99) >= 10;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx >= CSR_SECT0) sect_now[2'(idx - CSR_SECT0)] = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic send(logic [1:0] func, logic [1:0] drv, logic [47:0] lba,
                       logic [15:0] cnt, logic [31:0] addr, logic [15:0] bytes,
                       logic [7:0] tag, logic bus, logic [7:0] status);
      if (!calm) while ($urandom_range(99) < 10) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.func <= func;
      req_ch.drive_number <= drv;
      req_ch.start_lba <= lba;
      req_ch.sector_total <= cnt;
      req_ch.buffer_address <= addr;
      req_ch.buffer_bytes <= bytes;
      req_ch.request_tag <= tag;
      req_ch.report_bus <= bus;
      req_ch.bm_status_byte <= status;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // well-formed request with random content; mostly small counts
   task automatic good_request();
      logic [1:0]  drv;
      logic [15:0] cnt;
      logic [47:0] lba;
      drv = 2'($urandom_range(3));
      cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(127)) : 16'($urandom_range(16));
      if (sect_now[drv] <= 48'(cnt)) lba = 0;
      else lba = 48'({$urandom, $urandom} % (sect_now[drv] - 48'(cnt) + 48'd1));
      send($urandom_range(1), drv, lba, cnt, $urandom, cnt * 16'd512, next_tag++,
           1'b0, 8'd0);
   endtask

   task automatic random_item();
      int          pick;
      logic [15:0] cnt;
      pick = $urandom_range(99);
      if (pick < 50) good_request();
      else if (pick < 85) begin
         // status report: idle, error or busy, random upper bits
         send(FUNC_REPORT, 2'($urandom), 48'({$urandom, $urandom}), 16'($urandom),
              $urandom, 16'($urandom), next_tag++, 1'($urandom),
              {6'($urandom), 2'($urandom_range(2))});
      end else begin
         cnt = 16'($urandom);
         send(2'($urandom_range(3)), 2'($urandom), 48'({$urandom, $urandom}), cnt,
              $urandom, ($urandom_range(1) ? cnt * 16'd512 : 16'($urandom)), next_tag++,
              1'($urandom), 8'($urandom));
      end
   endtask

   task automatic load_setting(logic [15:0] bm, logic [31:0] prd, logic [3:0] pres,
                               logic [3:0] l48, logic [47:0] s0, logic [47:0] s1,
                               logic [47:0] s2, logic [47:0] s3);
      write_reg(CSR_BM_BASE, bm);
      write_reg(CSR_PRD_BASE, prd);
      write_reg(CSR_PRESENT, pres);
      write_reg(CSR_LBA48, l48);
      write_reg(CSR_SECT0, s0);
      write_reg(CSR_SECT1, s1);
      write_reg(CSR_SECT2, s2);
      write_reg(CSR_SECT3, s3);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_READ;
      req_ch.drive_number = '0;
      req_ch.start_lba = '0;
      req_ch.sector_total = '0;
      req_ch.buffer_address = '0;
      req_ch.buffer_bytes = '0;
      req_ch.request_tag = '0;
      req_ch.report_bus = 1'b0;
      req_ch.bm_status_byte = '0;
      foreach (sect_now[i]) sect_now[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      load_setting(16'hfffc, 32'hfffffffc, 4'b1110, 4'b0101, 48'd100,
                   48'hffff_ffff_ffff, 48'h1000_0000, 48'd40);
      // directed: absent drive, range, size, zero sectors, both formats, wrap
      send(FUNC_READ, 2'd0, 0, 1, 0, 512, 8'h00, 0, 0);
      send(FUNC_READ, 2'd3, 48'd40, 0, 0, 0, 8'h01, 0, 0);
      send(FUNC_READ, 2'd3, 48'd30, 16'd11, 0, 16'd5632, 8'h02, 0, 0);
      send(FUNC_WRITE, 2'd3, 48'd30, 16'd10, 0, 16'd5000, 8'h03, 0, 0);
      send(FUNC_WRITE, 2'd1, 48'hffff_ffff_fffe, 1, 32'hffffffff, 512, 8'hff, 0, 0);
      send(FUNC_READ, 2'd1, 48'h0000_ffff_0000, 16'hffff, 32'h0, 16'hfe00, 8'h04, 0, 0);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b0, 8'h01);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b0, 8'h02);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b0, 8'hff);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b0, 8'hfc);
      send(FUNC_NONE, 2'd1, 0, 1, 0, 512, 8'h05, 1'b1, 8'h00);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b1, 8'h00);
      send(FUNC_READ, 2'd2, 48'h0fff_ffff, 0, 32'h1234, 0, 8'h06, 0, 0);
      send(FUNC_WRITE, 2'd2, 48'h0abc_def0, 2, 32'h5678, 1024, 8'h07, 0, 0);
      send(FUNC_WRITE, 2'd3, 48'd0, 16'd40, 32'h9, 16'd20480, 8'h08, 0, 0);
      // fill the secondary queue to overflow
      repeat (7) send(FUNC_READ, 2'd2, 48'd5, 1, 32'h10, 512, next_tag++, 0, 0);
      send(FUNC_READ, 2'd2, 48'd5, 1, 32'h10, 512, 8'h09, 0, 0);
      repeat (9) send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b1, 8'h00);
      send(FUNC_REPORT, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00);
      drain();

      load_setting(16'h0000, 32'h0, 4'b1111, 4'b0000, 48'hffff_ffff_ffff,
                   48'd1000, 48'h3fff_ffff, 48'd17);
      repeat (90) random_item();
      // hold off until every result has come
      while (pending_count != 0) @(negedge clock);
      calm = 1'b1;
      repeat (40) random_item();
      calm = 1'b0;
      drain();

      load_setting(16'($urandom), $urandom, 4'($urandom) | 4'b0101, 4'($urandom),
                   48'($urandom_range(500)), {$urandom, $urandom},
                   48'($urandom), 48'($urandom_range(30)));
      repeat (110) random_item();
      drain();

      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
